FILE: src/skc_pkg.sv
// Shared types, constants and elaboration-time helpers for the soft-knee compressor.
// No dependencies; included by every other file through a wildcard import.
package skc_pkg;

   // configuration register map
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_KNEE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAKEUP  = 3'd5;

   // fixed-point constants
   localparam logic signed [15:0] ENV_FLOOR_Q8 = -16'sd23040;
   localparam logic signed [15:0] LVL_MIN_Q8   = -16'sd32768;
   localparam logic [12:0]        KNEE_MIN_Q8  = 13'd26;
   localparam logic [15:0]        RATIO_ONE_Q8 = 16'd256;
   localparam logic [12:0]        KNEE_RST_Q8  = 13'd1536;
   localparam logic [32:0]        DB_PER_OCT   = 33'd394566;
   localparam logic [32:0]        OCT_PER_DB   = 33'd10885;
   localparam logic [16:0]        GR_MAX       = 17'd32768;

   // sequencer step counter covers the 25 divider steps
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] SQ_LAST  = 5'd15;
   localparam logic [CNT_W-1:0] DIV_LAST = 5'd24;

   // datapath operations
   typedef logic [4:0] dp_op_type;
   localparam dp_op_type OP_NONE     = 5'd0;
   localparam dp_op_type OP_LOAD     = 5'd1;
   localparam dp_op_type OP_NORM     = 5'd2;
   localparam dp_op_type OP_SQ_INIT  = 5'd3;
   localparam dp_op_type OP_SQ       = 5'd4;
   localparam dp_op_type OP_LEVEL    = 5'd5;
   localparam dp_op_type OP_LVL_MIN  = 5'd6;
   localparam dp_op_type OP_ENV      = 5'd7;
   localparam dp_op_type OP_PREP     = 5'd8;
   localparam dp_op_type OP_DIV      = 5'd9;
   localparam dp_op_type OP_SLOPE    = 5'd10;
   localparam dp_op_type OP_ZERO     = 5'd11;
   localparam dp_op_type OP_LINR     = 5'd12;
   localparam dp_op_type OP_XX       = 5'd13;
   localparam dp_op_type OP_XXS      = 5'd14;
   localparam dp_op_type OP_KNEE     = 5'd15;
   localparam dp_op_type OP_LIN_E    = 5'd16;
   localparam dp_op_type OP_LIN_STEP = 5'd17;
   localparam dp_op_type OP_G30      = 5'd18;
   localparam dp_op_type OP_MK       = 5'd19;
   localparam dp_op_type OP_MKOV     = 5'd20;
   localparam dp_op_type OP_G18      = 5'd21;
   localparam dp_op_type OP_OUTL     = 5'd22;
   localparam dp_op_type OP_OUTR     = 5'd23;
   localparam dp_op_type OP_FINISH   = 5'd24;

   // exp source select
   localparam logic LIN_SRC_RED    = 1'b0;
   localparam logic LIN_SRC_MAKEUP = 1'b1;

   typedef struct packed {
      dp_op_type        op;
      logic             lin_src;
      logic [CNT_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic mag_zero;
      logic mag_top;
      logic knee_off;
      logic knee_lin;
      logic use_mk;
   } status_type;

   typedef struct packed {
      logic [15:0] attack;
      logic [15:0] release_c;
      logic [15:0] thresh;
      logic [15:0] ratio;
      logic [12:0] knee;
      logic [15:0] makeup;
   } cfg_type;

   // floored integer square root, used only at elaboration
   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bitv;
      x = v;
      res = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // 2^(2^-k) in Q30, built by repeated square roots from 2.0
   function automatic logic [30:0] root_q30(input int k);
      logic [63:0] r;
      r = 64'd1 << 31;
      for (int j = 0; j < 12; j++) begin
         if (j < k) begin
            r = isqrt64(r << 30);
         end
      end
      return r[30:0];
   endfunction

endpackage

FILE: src/skc_ctrl.sv
// Sequencer for the compressor: steps the datapath through one word at a time.
// Depends on skc_pkg for command and status types and operation codes.
module skc_ctrl import skc_pkg::*; #(
   parameter int DB_TABLE_BITS = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_NORM  = 5'd1;
   localparam logic [4:0] S_SQ    = 5'd2;
   localparam logic [4:0] S_LEVEL = 5'd3;
   localparam logic [4:0] S_ENV   = 5'd4;
   localparam logic [4:0] S_PREP  = 5'd5;
   localparam logic [4:0] S_DIVS  = 5'd6;
   localparam logic [4:0] S_SLOPE = 5'd7;
   localparam logic [4:0] S_GAIN  = 5'd8;
   localparam logic [4:0] S_XXS   = 5'd9;
   localparam logic [4:0] S_DIVK  = 5'd10;
   localparam logic [4:0] S_KNEE  = 5'd11;
   localparam logic [4:0] S_LINE  = 5'd12;
   localparam logic [4:0] S_LSTEP = 5'd13;
   localparam logic [4:0] S_G30   = 5'd14;
   localparam logic [4:0] S_MKE   = 5'd15;
   localparam logic [4:0] S_MSTEP = 5'd16;
   localparam logic [4:0] S_MK    = 5'd17;
   localparam logic [4:0] S_MKOV  = 5'd18;
   localparam logic [4:0] S_G18   = 5'd19;
   localparam logic [4:0] S_OUTL  = 5'd20;
   localparam logic [4:0] S_OUTR  = 5'd21;
   localparam logic [4:0] S_FIN   = 5'd22;

   localparam logic [CNT_W-1:0] LIN_LAST = CNT_W'(DB_TABLE_BITS - 1);

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_NONE;
      cmd.lin_src  = LIN_SRC_RED;
      cmd.idx      = cnt_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (status.mag_zero) begin
               cmd.op   = OP_LVL_MIN;
               state_in = S_ENV;
            end else if (status.mag_top) begin
               cmd.op   = OP_SQ_INIT;
               state_in = S_SQ;
            end else begin
               cmd.op = OP_NORM;
            end
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            if (cnt_ff == SQ_LAST) begin
               state_in = S_LEVEL;
            end
         end
         S_LEVEL: begin
            cmd.op   = OP_LEVEL;
            state_in = S_ENV;
         end
         S_ENV: begin
            cmd.op   = OP_ENV;
            state_in = S_PREP;
         end
         S_PREP: begin
            cmd.op   = OP_PREP;
            state_in = S_DIVS;
         end
         S_DIVS: begin
            cmd.op = OP_DIV;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_SLOPE;
            end
         end
         S_SLOPE: begin
            cmd.op   = OP_SLOPE;
            state_in = S_GAIN;
         end
         S_GAIN: begin
            if (status.knee_off) begin
               cmd.op   = OP_ZERO;
               state_in = S_LINE;
            end else if (status.knee_lin) begin
               cmd.op   = OP_LINR;
               state_in = S_LINE;
            end else begin
               cmd.op   = OP_XX;
               state_in = S_XXS;
            end
         end
         S_XXS: begin
            cmd.op   = OP_XXS;
            state_in = S_DIVK;
         end
         S_DIVK: begin
            cmd.op = OP_DIV;
            if (cnt_ff == DIV_LAST) begin
               state_in = S_KNEE;
            end
         end
         S_KNEE: begin
            cmd.op   = OP_KNEE;
            state_in = S_LINE;
         end
         S_LINE: begin
            cmd.op   = OP_LIN_E;
            state_in = S_LSTEP;
         end
         S_LSTEP: begin
            cmd.op = OP_LIN_STEP;
            if (cnt_ff == LIN_LAST) begin
               state_in = S_G30;
            end
         end
         S_G30: begin
            cmd.op   = OP_G30;
            state_in = status.use_mk ? S_MKOV : S_MKE;
         end
         S_MKE: begin
            cmd.op      = OP_LIN_E;
            cmd.lin_src = LIN_SRC_MAKEUP;
            state_in    = S_MSTEP;
         end
         S_MSTEP: begin
            cmd.op = OP_LIN_STEP;
            if (cnt_ff == LIN_LAST) begin
               state_in = S_MK;
            end
         end
         S_MK: begin
            cmd.op   = OP_MK;
            state_in = S_G18;
         end
         S_MKOV: begin
            cmd.op   = OP_MKOV;
            state_in = S_G18;
         end
         S_G18: begin
            cmd.op   = OP_G18;
            state_in = S_OUTL;
         end
         S_OUTL: begin
            cmd.op   = OP_OUTL;
            state_in = S_OUTR;
         end
         S_OUTR: begin
            cmd.op   = OP_OUTR;
            state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the result register is free
            if (slot_free) begin
               cmd.op       = OP_FINISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      cnt_in = (state_in == state_ff) ? cnt_ff + 1'b1 : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/skc_dp.sv
// Datapath: shared multiplier, restoring divider, envelope and metering state.
// Depends on skc_pkg; driven by skc_ctrl commands.
module skc_dp import skc_pkg::*; #(
   parameter int SAMPLE_WIDTH  = 24,
   parameter int DB_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  cmd_type                        cmd,
   output status_type                     status,
   input  cfg_type                        cfg,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic                           req_right_present,
   input  logic signed [15:0]             req_threshold_override_db,
   input  logic                           req_use_threshold_override,
   input  logic [15:0]                    req_ratio_override,
   input  logic                           req_use_ratio_override,
   input  logic [15:0]                    req_makeup_override,
   input  logic                           req_use_makeup_override,
   input  logic                           req_last_in_block,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out,
   output logic signed [15:0]             rsp_reduction_db,
   output logic signed [15:0]             rsp_peak_reduction_db,
   output logic                           rsp_block_end
);

   localparam int W    = SAMPLE_WIDTH;
   localparam int PW   = $clog2(SAMPLE_WIDTH);
   localparam int RT_W = $clog2(DB_TABLE_BITS);
   localparam logic signed [47:0] SAT_HI = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
   localparam logic signed [47:0] SAT_LO = -SAT_HI - 48'sd1;

   logic [30:0] root_tab [DB_TABLE_BITS];

   for (genvar g = 0; g < DB_TABLE_BITS; g++) begin : g_root
      localparam logic [30:0] ROOT = root_q30(g + 1);
      assign root_tab[g] = ROOT;
   end

   // captured word
   logic signed [W-1:0] l_ff, l_in, r_ff, r_in;
   logic                stereo_ff, stereo_in, last_ff, last_in;
   logic signed [15:0]  thr_ff, thr_in;
   logic [15:0]         rat_ff, rat_in, mkov_ff, mkov_in;
   logic                use_mk_ff, use_mk_in;
   // working registers
   logic [W-1:0]        mag_ff, mag_in;
   logic [PW-1:0]       p_ff, p_in;
   logic [30:0]         sq_ff, sq_in;
   logic [15:0]         frac_ff, frac_in;
   logic signed [15:0]  lvl_ff, lvl_in;
   logic signed [15:0]  env_ff, env_in;
   logic signed [17:0]  over_ff, over_in;
   logic [12:0]         kn_ff, kn_in;
   logic [24:0]         quo_ff, quo_in;
   logic [15:0]         rem_ff, rem_in, dvs_ff, dvs_in;
   logic [15:0]         slope_ff, slope_in;
   logic [27:0]         xx_ff, xx_in;
   logic signed [15:0]  red_ff, red_in;
   logic signed [5:0]   n_ff, n_in;
   logic [15:0]         f_ff, f_in;
   logic [30:0]         acc_ff, acc_in, g30_ff, g30_in;
   logic [15:0]         mk_ff, mk_in;
   logic [23:0]         g18_ff, g18_in;
   logic signed [W-1:0] lo_ff, lo_in, ro_ff, ro_in;
   logic signed [15:0]  pk_ff, pk_in;
   logic                out_load;
   logic signed [15:0]  pk_new;

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic [W-1:0]        abs_l, abs_r;
   logic signed [6:0]   pdel;
   logic signed [22:0]  lval;
   logic signed [41:0]  lvl_wide;
   logic                env_gt;
   logic [15:0]         coeff;
   logic [16:0]         cw;
   logic signed [16:0]  dif;
   logic signed [65:0]  env_sum;
   logic signed [49:0]  env_new;
   logic signed [18:0]  two_over, kn_s;
   logic [13:0]         xv;
   logic [16:0]         rem_sh;
   logic                div_ge;
   logic [15:0]         rat_eff;
   logic [12:0]         kn_eff;
   logic [49:0]         gr_lin;
   logic [16:0]         gr_c;
   logic signed [15:0]  lin_d;
   logic signed [57:0]  e_w;
   logic [RT_W-1:0]     rj;
   logic [3:0]          fi;
   logic [5:0]          nneg;
   logic [6:0]          mk_sh;
   logic [30:0]         mk_v;
   logic signed [47:0]  out_w;
   logic signed [W-1:0] sat_v;

   assign abs_l    = l_ff[W-1] ? W'(~l_ff + 1'b1) : W'(l_ff);
   assign abs_r    = r_ff[W-1] ? W'(~r_ff + 1'b1) : W'(r_ff);
   assign pdel     = $signed(7'(p_ff)) - 7'(SAMPLE_WIDTH - 1);
   assign lval     = $signed({pdel, frac_ff});
   assign lvl_wide = $signed(mul_p[65:24]);
   assign env_gt   = lvl_ff > env_ff;
   assign coeff    = env_gt ? cfg.attack : cfg.release_c;
   assign cw       = 17'd65536 - 17'(coeff);
   assign dif      = 17'(lvl_ff) - 17'(env_ff);
   assign env_sum  = mul_p + 66'sd32768;
   assign env_new  = 50'(env_ff) + $signed(env_sum[65:16]);
   assign two_over = $signed({over_ff, 1'b0});
   assign kn_s     = $signed({6'b0, kn_ff});
   assign xv       = 14'(two_over + kn_s);
   assign rem_sh   = {rem_ff, quo_ff[24]};
   assign div_ge   = rem_sh >= {1'b0, dvs_ff};
   assign rat_eff  = (rat_ff < RATIO_ONE_Q8) ? RATIO_ONE_Q8 : rat_ff;
   assign kn_eff   = (cfg.knee < KNEE_MIN_Q8) ? KNEE_MIN_Q8 : cfg.knee;
   assign gr_lin   = mul_p[65:16];
   assign lin_d    = (cmd.lin_src == LIN_SRC_MAKEUP) ? $signed(cfg.makeup) : red_ff;
   assign e_w      = $signed(mul_p[65:8]);
   assign rj       = cmd.idx[RT_W-1:0];
   assign fi       = 4'd15 - 4'(rj);
   assign nneg     = 6'(-n_ff);
   assign mk_sh    = 7'd18 - 7'(n_ff);
   assign mk_v     = acc_ff >> mk_sh;
   assign out_w    = $signed(mul_p[65:18]);
   assign sat_v    = (out_w > SAT_HI) ? W'(SAT_HI) :
                     (out_w < SAT_LO) ? W'(SAT_LO) : W'(out_w);
   assign pk_new   = (red_ff < pk_ff) ? red_ff : pk_ff;
   assign out_load = (cmd.op == OP_FINISH);

   assign status.mag_zero = (mag_ff == '0);
   assign status.mag_top  = mag_ff[W-1];
   assign status.knee_off = two_over <= -kn_s;
   assign status.knee_lin = two_over >= kn_s;
   assign status.use_mk   = use_mk_ff;

   always_comb begin
      l_in = l_ff;       r_in = r_ff;       stereo_in = stereo_ff; last_in = last_ff;
      thr_in = thr_ff;   rat_in = rat_ff;   mkov_in = mkov_ff;     use_mk_in = use_mk_ff;
      mag_in = mag_ff;   p_in = p_ff;       sq_in = sq_ff;         frac_in = frac_ff;
      lvl_in = lvl_ff;   env_in = env_ff;   over_in = over_ff;     kn_in = kn_ff;
      quo_in = quo_ff;   rem_in = rem_ff;   dvs_in = dvs_ff;       slope_in = slope_ff;
      xx_in = xx_ff;     red_in = red_ff;   n_in = n_ff;           f_in = f_ff;
      acc_in = acc_ff;   g30_in = g30_ff;   mk_in = mk_ff;         g18_in = g18_ff;
      lo_in = lo_ff;     ro_in = ro_ff;     pk_in = pk_ff;
      gr_c  = '0;
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LOAD: begin
            l_in      = req_left_sample;
            r_in      = req_right_sample;
            stereo_in = req_right_present;
            last_in   = req_last_in_block;
            thr_in    = req_use_threshold_override ? req_threshold_override_db
                                                   : $signed(cfg.thresh);
            rat_in    = req_use_ratio_override ? req_ratio_override : cfg.ratio;
            mkov_in   = req_makeup_override;
            use_mk_in = req_use_makeup_override;
            mag_in    = (req_right_present && (abs_r > abs_l)) ? abs_r : abs_l;
            mag_in    = req_left_sample[W-1] ? W'(~req_left_sample + 1'b1)
                                             : W'(req_left_sample);
            if (req_right_present) begin
               if ((req_right_sample[W-1] ? W'(~req_right_sample + 1'b1)
                                          : W'(req_right_sample)) > mag_in) begin
                  mag_in = req_right_sample[W-1] ? W'(~req_right_sample + 1'b1)
                                                 : W'(req_right_sample);
               end
            end
            p_in = PW'(SAMPLE_WIDTH - 1);
         end
         OP_NORM: begin
            mag_in = mag_ff << 1;
            p_in   = p_ff - 1'b1;
         end
         OP_SQ_INIT: begin
            sq_in   = {mag_ff[W-1 -: DB_TABLE_BITS+1], (30 - DB_TABLE_BITS)'(0)};
            frac_in = '0;
         end
         OP_SQ: begin
            mul_a   = 33'(sq_ff);
            mul_b   = 33'(sq_ff);
            frac_in = {frac_ff[14:0], mul_p[61]};
            sq_in   = mul_p[61] ? mul_p[61:31] : mul_p[60:30];
         end
         OP_LEVEL: begin
            mul_a  = 33'(lval);
            mul_b  = DB_PER_OCT;
            lvl_in = (lvl_wide < 42'(LVL_MIN_Q8)) ? LVL_MIN_Q8 : 16'(lvl_wide);
         end
         OP_LVL_MIN: begin
            lvl_in = LVL_MIN_Q8;
         end
         OP_ENV: begin
            mul_a  = 33'(cw);
            mul_b  = 33'(dif);
            env_in = (env_new < 50'(ENV_FLOOR_Q8)) ? ENV_FLOOR_Q8 : 16'(env_new);
         end
         OP_PREP: begin
            over_in = 18'(env_ff) - 18'(thr_ff);
            kn_in   = kn_eff;
            quo_in  = 25'(1 << 24) + 25'(rat_eff >> 1);
            rem_in  = '0;
            dvs_in  = rat_eff;
         end
         OP_DIV: begin
            rem_in = div_ge ? 16'(rem_sh - {1'b0, dvs_ff}) : rem_sh[15:0];
            quo_in = {quo_ff[23:0], div_ge};
         end
         OP_SLOPE: begin
            slope_in = 16'(17'd65536 - quo_ff[16:0]);
         end
         OP_ZERO: begin
            red_in = '0;
         end
         OP_LINR: begin
            mul_a  = 33'(over_ff);
            mul_b  = 33'(slope_ff);
            gr_c   = (gr_lin > 50'(GR_MAX)) ? GR_MAX : gr_lin[16:0];
            red_in = 16'(-gr_c);
         end
         OP_XX: begin
            mul_a = 33'(xv);
            mul_b = 33'(xv);
            xx_in = mul_p[27:0];
         end
         OP_XXS: begin
            mul_a  = 33'(xx_ff);
            mul_b  = 33'(slope_ff);
            quo_in = mul_p[43:19];
            rem_in = '0;
            dvs_in = 16'(kn_ff);
         end
         OP_KNEE: begin
            gr_c   = (quo_ff > 25'(GR_MAX)) ? GR_MAX : quo_ff[16:0];
            red_in = 16'(-gr_c);
         end
         OP_LIN_E: begin
            mul_a  = 33'(lin_d);
            mul_b  = OCT_PER_DB;
            n_in   = e_w[21:16];
            f_in   = e_w[15:0];
            acc_in = 31'(1 << 30);
         end
         OP_LIN_STEP: begin
            mul_a = 33'(acc_ff);
            mul_b = 33'(root_tab[rj]);
            if (f_ff[fi]) begin
               acc_in = mul_p[60:30];
            end
         end
         OP_G30: begin
            g30_in = n_ff[5] ? (acc_ff >> nneg) : acc_ff;
         end
         OP_MK: begin
            if (n_ff >= 6'sd4) begin
               mk_in = 16'hFFFF;
            end else begin
               mk_in = (mk_v > 31'd65535) ? 16'hFFFF : mk_v[15:0];
            end
         end
         OP_MKOV: begin
            mk_in = mkov_ff;
         end
         OP_G18: begin
            mul_a  = 33'(g30_ff);
            mul_b  = 33'(mk_ff);
            g18_in = mul_p[47:24];
         end
         OP_OUTL: begin
            mul_a = 33'(l_ff);
            mul_b = 33'(g18_ff);
            lo_in = sat_v;
         end
         OP_OUTR: begin
            mul_a = 33'(r_ff);
            mul_b = 33'(g18_ff);
            ro_in = stereo_ff ? sat_v : '0;
         end
         OP_FINISH: begin
            // drop the meter back to zero after the block's last word
            pk_in = last_ff ? '0 : pk_new;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= ENV_FLOOR_Q8;
         pk_ff  <= '0;
      end else begin
         env_ff <= env_in;
         pk_ff  <= pk_in;
      end
   end

   always_ff @(posedge clock) begin
      l_ff <= l_in;       r_ff <= r_in;       stereo_ff <= stereo_in; last_ff <= last_in;
      thr_ff <= thr_in;   rat_ff <= rat_in;   mkov_ff <= mkov_in;     use_mk_ff <= use_mk_in;
      mag_ff <= mag_in;   p_ff <= p_in;       sq_ff <= sq_in;         frac_ff <= frac_in;
      lvl_ff <= lvl_in;   over_ff <= over_in; kn_ff <= kn_in;
      quo_ff <= quo_in;   rem_ff <= rem_in;   dvs_ff <= dvs_in;       slope_ff <= slope_in;
      xx_ff <= xx_in;     red_ff <= red_in;   n_ff <= n_in;           f_ff <= f_in;
      acc_ff <= acc_in;   g30_ff <= g30_in;   mk_ff <= mk_in;         g18_ff <= g18_in;
      lo_ff <= lo_in;     ro_ff <= ro_in;
      if (out_load) begin
         rsp_left_out          <= lo_ff;
         rsp_right_out         <= ro_ff;
         rsp_reduction_db      <= red_ff;
         rsp_peak_reduction_db <= pk_new;
         rsp_block_end         <= last_ff;
      end
   end

endmodule

FILE: src/soft_knee_stereo_compressor.sv
// Steps each word through the normalising shift of its peak, one bit per step, the 16 log
// squarings, the envelope, the 25-step divider, the gain computer, the reduction exp, the
// makeup exp and the outputs; a silent peak skips the squarings, the knee interpolation runs
// only inside the knee and the makeup exp only without a per-word makeup gain. Most of the
// work is on one shared multiplier. The next word is taken once the sequencer is idle,
// also while a finished result waits. Reset: synchronous, active high; envelope to -90 dB.
module soft_knee_stereo_compressor import skc_pkg::*; #(
   parameter int SAMPLE_WIDTH  = 24,
   parameter int DB_TABLE_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0] req_left_sample,
   input  logic signed [SAMPLE_WIDTH-1:0] req_right_sample,
   input  logic                           req_right_present,
   input  logic signed [15:0]             req_threshold_override_db,
   input  logic                           req_use_threshold_override,
   input  logic [15:0]                    req_ratio_override,
   input  logic                           req_use_ratio_override,
   input  logic [15:0]                    req_makeup_override,
   input  logic                           req_use_makeup_override,
   input  logic                           req_last_in_block,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_right_out,
   output logic signed [15:0]             rsp_reduction_db,
   output logic signed [15:0]             rsp_peak_reduction_db,
   output logic                           rsp_block_end,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_IDX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_data
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   // Register writes are always taken; an unknown index is simply dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ATTACK:  cfg_in.attack    = csr_data;
            CSR_RELEASE: cfg_in.release_c = csr_data;
            CSR_THRESH:  cfg_in.thresh    = csr_data;
            CSR_RATIO:   cfg_in.ratio     = csr_data;
            CSR_KNEE:    cfg_in.knee      = csr_data[12:0];
            CSR_MAKEUP:  cfg_in.makeup    = csr_data;
            default:     cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack    <= '0;
         cfg_ff.release_c <= '0;
         cfg_ff.thresh    <= '0;
         cfg_ff.ratio     <= RATIO_ONE_Q8;
         cfg_ff.knee      <= KNEE_RST_Q8;
         cfg_ff.makeup    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The sequencer owns both handshakes: it takes a word only when idle and
   // parks the finished result in the output register held inside the datapath.
   skc_ctrl #(
      .DB_TABLE_BITS(DB_TABLE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Level detection, envelope, gain computer, exp and gain application.
   skc_dp #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .DB_TABLE_BITS(DB_TABLE_BITS)
   ) u_dp (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .status                    (status),
      .cfg                       (cfg_ff),
      .req_left_sample           (req_left_sample),
      .req_right_sample          (req_right_sample),
      .req_right_present         (req_right_present),
      .req_threshold_override_db (req_threshold_override_db),
      .req_use_threshold_override(req_use_threshold_override),
      .req_ratio_override        (req_ratio_override),
      .req_use_ratio_override    (req_use_ratio_override),
      .req_makeup_override       (req_makeup_override),
      .req_use_makeup_override   (req_use_makeup_override),
      .req_last_in_block         (req_last_in_block),
      .rsp_left_out              (rsp_left_out),
      .rsp_right_out             (rsp_right_out),
      .rsp_reduction_db          (rsp_reduction_db),
      .rsp_peak_reduction_db     (rsp_peak_reduction_db),
      .rsp_block_end             (rsp_block_end)
   );

   // A taken word always starts a multi-cycle run.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input taken again straight after a word");

   // Gain change is never positive.
   a_reduction_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_reduction_db[15] || (rsp_reduction_db == 16'sd0)))
      else $error("positive gain reduction");

   // The block meter is at least as deep as the current reduction.
   a_peak_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_peak_reduction_db <= rsp_reduction_db))
      else $error("peak reduction shallower than current reduction");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the soft-knee stereo compressor: directed and random sample words.
// Depends on skc_pkg and the soft_knee_stereo_compressor RTL; holds its own bit-true predictor.
module testbench import skc_pkg::*; ();

   localparam int SW        = 24;
   localparam int TBITS     = 8;
   localparam int WATCHDOG  = 20000;
   localparam int LONG_HOLD = 3000;

   // register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic signed [SW-1:0] left_out;
      logic signed [SW-1:0] right_out;
      logic signed [15:0]   red_db;
      logic signed [15:0]   peak_db;
      logic                 blk_end;
   } gain_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [SW-1:0] req_left_sample = '0;
   logic signed [SW-1:0] req_right_sample = '0;
   logic                 req_right_present = 1'b0;
   logic signed [15:0]   req_threshold_override_db = '0;
   logic                 req_use_threshold_override = 1'b0;
   logic [15:0]          req_ratio_override = '0;
   logic                 req_use_ratio_override = 1'b0;
   logic [15:0]          req_makeup_override = '0;
   logic                 req_use_makeup_override = 1'b0;
   logic                 req_last_in_block = 1'b0;

   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [SW-1:0] rsp_left_out;
   logic signed [SW-1:0] rsp_right_out;
   logic signed [15:0]   rsp_reduction_db;
   logic signed [15:0]   rsp_peak_reduction_db;
   logic                 rsp_block_end;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   soft_knee_stereo_compressor #(.SAMPLE_WIDTH(SW), .DB_TABLE_BITS(TBITS)) dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // predictor state and shadow registers
   logic [15:0]      sh_attack, sh_release, sh_thresh, sh_ratio, sh_makeup;
   logic [12:0]      sh_knee;
   longint           env_db;
   longint           meter_db;
   gain_result_type  pending_words[$];
   int               mismatches = 0;
   int               idle_pct   = 18;   // idling percentage, 0 for a stretch without gaps
   bit               rsp_hold   = 1'b0; // receiver holds off entirely
   int               quiet_cycles = 0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint peak_to_db(longint unsigned mag);
      int p;
      longint unsigned m;
      longint unsigned fr;
      longint l, d;
      if (mag == 0) return -32768;
      p = 63;
      while (mag[p] == 1'b0) p--;
      m = (p <= 30) ? (mag << (30 - p)) : (mag >> (p - 30));
      m &= ~((64'd1 << (30 - TBITS)) - 1);
      fr = 0;
      for (int i = 0; i < 16; i++) begin
         fr <<= 1;
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            fr |= 1;
            m >>= 1;
         end
      end
      l = (longint'(p) - (SW - 1)) * 65536 + longint'(fr);
      d = floor_shr(l * 394566, 24);
      if (d < -32768) d = -32768;
      return d;
   endfunction

   // dB Q7.8 to mantissa Q30 and octave
   function automatic longint unsigned db_to_gain(longint d, output int oct);
      longint e, n;
      longint unsigned f, acc, r;
      e = floor_shr(d * 10885, 8);
      n = floor_shr(e, 16);
      f = e - n * 65536;
      acc = 64'd1 << 30;
      r = 64'd1 << 31;
      for (int k = 1; k <= TBITS; k++) begin
         r = int_sqrt(r << 30);
         if ((f >> (16 - k)) & 1) acc = (acc * r) >> 30;
      end
      oct = int'(n);
      return acc;
   endfunction

   function automatic logic signed [SW-1:0] clip_sample(longint v);
      longint hi, lo;
      hi = (longint'(1) << (SW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return v[SW-1:0];
   endfunction

   // work out the result word for one accepted sample word, advancing the envelope and meter
   function automatic gain_result_type compress_sample(
      logic signed [SW-1:0] ls, logic signed [SW-1:0] rs, logic stereo,
      logic signed [15:0] thr_ov, logic use_thr, logic [15:0] rat_ov, logic use_rat,
      logic [15:0] mk_ov, logic use_mk, logic last);
      gain_result_type res;
      longint l, r, thr, lvl, env, over, gr, red, knee, c;
      longint unsigned mag, mr, rat, slope, x, m, g30, mk, g18;
      int n;
      l = ls;
      r = rs;
      thr = use_thr ? longint'(thr_ov) : longint'($signed(sh_thresh));
      rat = use_rat ? rat_ov : sh_ratio;
      mag = (l < 0) ? -l : l;
      if (stereo) begin
         mr = (r < 0) ? -r : r;
         if (mr > mag) mag = mr;
      end
      lvl = peak_to_db(mag);
      c = (lvl > env_db) ? sh_attack : sh_release;
      env = floor_shr(c * env_db + (65536 - c) * lvl + 32768, 16);
      if (env < -23040) env = -23040;
      env_db = env;
      if (rat < 256) rat = 256;
      slope = 65536 - (((64'd1 << 24) + rat / 2) / rat);
      knee = (sh_knee < 26) ? 26 : sh_knee;
      over = env_db - thr;
      if (2 * over <= -knee) begin
         gr = 0;
      end else if (2 * over >= knee) begin
         gr = (longint'(over) * longint'(slope)) >>> 16;
      end else begin
         x = 2 * over + knee;
         gr = (x * x * slope) / (longint'(knee) << 19);
      end
      if (gr > 32768) gr = 32768;
      red = -gr;
      m = db_to_gain(red, n);
      g30 = (n <= -40) ? 0 : ((n >= 0) ? m : (m >> (-n)));
      if (use_mk) begin
         mk = mk_ov;
      end else begin
         m = db_to_gain(longint'($signed(sh_makeup)), n);
         if (n >= 4) mk = 65535;
         else if (18 - n >= 63) mk = 0;
         else begin
            mk = m >> (18 - n);
            if (mk > 65535) mk = 65535;
         end
      end
      g18 = (g30 * mk) >> 24;
      res.left_out  = clip_sample(floor_shr(l * longint'(g18), 18));
      res.right_out = stereo ? clip_sample(floor_shr(r * longint'(g18), 18)) : '0;
      if (red < meter_db) meter_db = red;
      res.red_db  = red[15:0];
      res.peak_db = meter_db[15:0];
      res.blk_end = last;
      if (last) meter_db = 0;
      return res;
   endfunction

   // send one sample word; the expectation is queued at the accepting edge
   task automatic send_sample(logic signed [SW-1:0] ls, logic signed [SW-1:0] rs,
                              logic stereo, logic signed [15:0] thr_ov, logic use_thr,
                              logic [15:0] rat_ov, logic use_rat, logic [15:0] mk_ov,
                              logic use_mk, logic last);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(posedge clock);
      req_valid                  <= 1'b1;
      req_left_sample            <= ls;
      req_right_sample           <= rs;
      req_right_present          <= stereo;
      req_threshold_override_db  <= thr_ov;
      req_use_threshold_override <= use_thr;
      req_ratio_override         <= rat_ov;
      req_use_ratio_override     <= use_rat;
      req_makeup_override        <= mk_ov;
      req_use_makeup_override    <= use_mk;
      req_last_in_block          <= last;
      do @(posedge clock); while (!req_ready);
      pending_words.push_back(compress_sample(ls, rs, stereo, thr_ov, use_thr, rat_ov,
                                              use_rat, mk_ov, use_mk, last));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random_sample();
      logic [15:0] rat;
      rat = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(256, 2560));
      send_sample(SW'($urandom) >>> $urandom_range(SW - 1),
                  SW'($urandom) >>> $urandom_range(SW - 1),
                  1'($urandom),
                  $urandom_range(1) ? 16'($urandom)
                                    : 16'($urandom_range(0, 12000) - 12000),
                  1'($urandom), rat, 1'($urandom),
                  16'($urandom), 1'($urandom), $urandom_range(7) == 0);
   endtask

   // register write, only while nothing is in flight
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ATTACK:  sh_attack  = val;
         CSR_RELEASE: sh_release = val;
         CSR_THRESH:  sh_thresh  = val;
         CSR_RATIO:   sh_ratio   = val;
         CSR_KNEE:    sh_knee    = val[12:0];
         CSR_MAKEUP:  sh_makeup  = val;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every expected word, then the block's worst latency
   task automatic drain();
      while (pending_words.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] att, logic [15:0] rel, logic [15:0] thr,
                           logic [15:0] rat, logic [15:0] knee, logic [15:0] mk);
      drain();
      write_reg(CSR_ATTACK, att);
      write_reg(CSR_RELEASE, rel);
      write_reg(CSR_THRESH, thr);
      write_reg(CSR_RATIO, rat);
      write_reg(CSR_KNEE, knee);
      write_reg(CSR_MAKEUP, mk);
   endtask

   task automatic test_directed();
      logic signed [SW-1:0] maxp, maxn;
      maxp = {1'b0, {(SW-1){1'b1}}};
      maxn = {1'b1, {(SW-1){1'b0}}};
      // silence, full scale both signs, mono with a loud ignored right
      send_sample('0, '0, 1'b1, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
      send_sample(maxp, maxn, 1'b1, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
      send_sample(maxn, maxp, 1'b1, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
      send_sample(SW'(1), maxn, 1'b0, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
      send_sample(-SW'(1), SW'(3), 1'b1, '0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b1);
      // overrides at their extremes: threshold, ratio below one and maximum, makeup
      send_sample(maxp, maxp, 1'b1, 16'sh8000, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0);
      send_sample(maxn, '0, 1'b1, 16'sh8000, 1'b1, 16'hFFFF, 1'b1, 16'h0000, 1'b1, 1'b0);
      send_sample(maxp, maxn, 1'b1, 16'sh7FFF, 1'b1, 16'h0100, 1'b1, 16'h1000, 1'b1, 1'b1);
      send_sample(SW'(4096), -SW'(4096), 1'b1, -16'sd6000, 1'b1, 16'h0400, 1'b1, 16'h1000,
                  1'b1, 1'b0);
      send_sample(maxp, maxp, 1'b0, 16'sh8000, 1'b1, 16'hFFFF, 1'b1, '0, 1'b0, 1'b1);
   endtask

   task automatic test_register_extremes();
      // deep reduction and saturating makeup
      set_regs(16'h0000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'd26, 16'h7FFF);
      repeat (6) send_random_sample();
      // tiny makeup, knee below its minimum, ratio below one
      set_regs(16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 16'd0, 16'h8000);
      repeat (6) send_random_sample();
      set_regs(16'h8000, 16'hF000, -16'sd3072, 16'h0400, 16'h1FFF, 16'd1536);
      repeat (6) send_random_sample();
      // unknown register indexes are ignored
      drain();
      write_reg(CSR_SPARE_A, 16'hFFFF);
      write_reg(CSR_SPARE_B, 16'h5555);
   endtask

   task automatic test_random_phases();
      for (int ph = 0; ph < 5; ph++) begin
         set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(0, 9000) - 9000),
                  16'($urandom_range(256, 4096)), 16'($urandom_range(26, 6144)),
                  16'($urandom_range(0, 3000) - 1500));
         idle_pct = (ph == 2) ? 0 : 18;
         repeat (110) send_random_sample();
      end
      idle_pct = 18;
   endtask

   task automatic test_backpressure();
      // receiver holds off while the sender keeps offering words
      fork
         begin
            rsp_hold = 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold = 1'b0;
         end
         repeat (20) send_random_sample();
      join
      // sender pauses until every expected word has come
      while (pending_words.size() != 0) @(posedge clock);
      repeat (20) send_random_sample();
   endtask

   // receiver readiness
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && (idle_pct == 0 || $urandom_range(99) >= idle_pct);
      end
   end

   // compare each result word against the oldest expectation
   always @(posedge clock) begin
      gain_result_type exp_w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word");
         end else begin
            exp_w = pending_words.pop_front();
            if (rsp_left_out !== exp_w.left_out || rsp_right_out !== exp_w.right_out ||
                rsp_reduction_db !== exp_w.red_db || rsp_peak_reduction_db !== exp_w.peak_db ||
                rsp_block_end !== exp_w.blk_end) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp l=%0d r=%0d red=%0d pk=%0d end=%0b",
                            " got l=%0d r=%0d red=%0d pk=%0d end=%0b"},
                           exp_w.left_out, exp_w.right_out, exp_w.red_db, exp_w.peak_db,
                           exp_w.blk_end, rsp_left_out, rsp_right_out, rsp_reduction_db,
                           rsp_peak_reduction_db, rsp_block_end);
            end
         end
      end
   end

   // watchdog: cycles with no word accepted anywhere
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("FAIL soft_knee_stereo_compressor");
         $finish;
      end
   end

   initial begin
      sh_attack = '0; sh_release = '0; sh_thresh = '0;
      sh_ratio = RATIO_ONE_Q8; sh_knee = KNEE_RST_Q8; sh_makeup = '0;
      env_db = -23040;
      meter_db = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_extremes();
      test_backpressure();
      test_random_phases();
      drain();
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("PASS soft_knee_stereo_compressor");
      end else begin
         $display("FAIL soft_knee_stereo_compressor");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/skc_pkg.sv
src/skc_ctrl.sv
src/skc_dp.sv
src/soft_knee_stereo_compressor.sv
tb/testbench.sv
